// ----- rtl/core/mi_pkg.sv -----
package mi_pkg;

	localparam int unsigned Width = 31;
	localparam int unsigned KWidth = $clog2(Width);

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SHL,
		OP_SUB_SHR,
		OP_SUB_SWAP
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ALIGN,
		S_SUBT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_INV  = 2'd1,
		STAT_BAD_MOD = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [Width-1:0] ld_r0;
		logic [Width-1:0] ld_r1;
	} ctrl_t;

endpackage

// ----- rtl/core/mi_req_if.sv -----
interface mi_req_if;
	import mi_pkg::*;

	logic             valid;
	logic             ready;
	logic [Width-1:0] value;
	logic [Width-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

// ----- rtl/core/mi_rsp_if.sv -----
interface mi_rsp_if;
	import mi_pkg::*;

	logic             valid;
	logic             ready;
	logic [Width-1:0] inverse;
	logic [Width-1:0] divisor;
	logic [1:0]       status;

	modport source (output valid, output inverse, output divisor, output status, input ready);
	modport sink (input valid, input inverse, input divisor, input status, output ready);
endinterface

// ----- rtl/core/modular_inverse_with_gcd_check_core.sv -----
// channel | dir | payload                  | handshake
// req     | in  | value, modulus           | valid/ready
// rsp     | out | inverse, divisor, status | valid/ready
//
// one request at a time; each euclid step shifts the divisor up one place per cycle in
// the bit-slice chain, then subtracts and shifts it back down, plus per request an accept,
// a final check and a hand-off
// reset clears only the controller state and the response valid; the datapath cells are reloaded per request
// a finished response waits in the output register while a new request is taken
module modular_inverse_with_gcd_check_core (
	input logic      clk,
	input logic      arst_n,
	mi_req_if.sink   req,
	mi_rsp_if.source rsp
);
	import mi_pkg::*;

	ctrl_t            ctrl;
	logic [Width-1:0] r0, r1, s1;
	logic [Width:0]   bc, bsc, cc;

	assign bc[0]  = 1'b0;
	assign bsc[0] = 1'b0;
	assign cc[0]  = 1'b0;

	for (genvar i = 0; i < Width; i++) begin : g_cell
		logic r1_lo, s1_lo, r1_hi, s1_hi;
		if (i == 0) begin : g_lo0
			assign r1_lo = 1'b0;
			assign s1_lo = 1'b0;
		end else begin : g_lo
			assign r1_lo = r1[i-1];
			assign s1_lo = s1[i-1];
		end
		if (i == Width - 1) begin : g_hi0
			assign r1_hi = 1'b0;
			assign s1_hi = 1'b0;
		end else begin : g_hi
			assign r1_hi = r1[i+1];
			assign s1_hi = s1[i+1];
		end
		mi_cell u_cell (
			.clk   (clk),
			.op    (ctrl.op),
			.ld_r0 (ctrl.ld_r0[i]),
			.ld_r1 (ctrl.ld_r1[i]),
			.ld_s1 (i == 0),
			.r1_lo (r1_lo),
			.s1_lo (s1_lo),
			.r1_hi (r1_hi),
			.s1_hi (s1_hi),
			.bin   (bc[i]),
			.bsin  (bsc[i]),
			.cin   (cc[i]),
			.ge    (~bc[Width]),
			.r0    (r0[i]),
			.r1    (r1[i]),
			.s1    (s1[i]),
			.bout  (bc[i+1]),
			.bsout (bsc[i+1]),
			.cout  (cc[i+1])
		);
	end

	mi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.r0     (r0),
		.r1     (r1),
		.s1     (s1),
		.ge_sh  (~bsc[Width] & ~cc[Width] | ~bsc[Width]),
		.ctrl   (ctrl)
	);
endmodule

// ----- rtl/core/mi_cell.sv -----
module mi_cell (
	input  logic          clk,
	input  mi_pkg::op_t   op,
	input  logic          ld_r0,
	input  logic          ld_r1,
	input  logic          ld_s1,
	input  logic          r1_lo,
	input  logic          s1_lo,
	input  logic          r1_hi,
	input  logic          s1_hi,
	input  logic          bin,
	input  logic          bsin,
	input  logic          cin,
	input  logic          ge,
	output logic          r0,
	output logic          r1,
	output logic          s1,
	output logic          bout,
	output logic          bsout,
	output logic          cout
);
	import mi_pkg::*;

	logic r0_q, r1_q, s0_q, s1_q;
	logic diff, sum;

	assign r0 = r0_q;
	assign r1 = r1_q;
	assign s1 = s1_q;

	// r0 - r1, r0 - (r1 << 1), s0 + s1
	assign diff  = r0_q ^ r1_q ^ bin;
	assign bout  = (~r0_q & r1_q) | (~(r0_q ^ r1_q) & bin);
	assign bsout = (~r0_q & r1_lo) | (~(r0_q ^ r1_lo) & bsin);
	assign sum   = s0_q ^ s1_q ^ cin;
	assign cout  = (s0_q & s1_q) | (cin & (s0_q ^ s1_q));

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				r0_q <= ld_r0;
				r1_q <= ld_r1;
				s0_q <= 1'b0;
				s1_q <= ld_s1;
			end
			OP_SHL: begin
				r1_q <= r1_lo;
				s1_q <= s1_lo;
			end
			OP_SUB_SHR: begin
				if (ge) begin
					r0_q <= diff;
					s0_q <= sum;
				end
				r1_q <= r1_hi;
				s1_q <= s1_hi;
			end
			OP_SUB_SWAP: begin
				r0_q <= r1_q;
				s0_q <= s1_q;
				r1_q <= ge ? diff : r0_q;
				s1_q <= ge ? sum : s0_q;
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- rtl/core/mi_ctrl.sv -----
module mi_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	mi_req_if.sink                   req,
	mi_rsp_if.source                 rsp,
	input  logic [mi_pkg::Width-1:0] r0,
	input  logic [mi_pkg::Width-1:0] r1,
	input  logic [mi_pkg::Width-1:0] s1,
	input  logic                     ge_sh,
	output mi_pkg::ctrl_t            ctrl
);
	import mi_pkg::*;

	state_t            state_q, state_d;
	logic [KWidth-1:0] k_q;
	logic [Width-1:0]  m_q;
	logic [Width-1:0]  inv_q;
	logic              odd_q;
	logic              shl;
	logic              out_free;
	logic              out_valid_q;
	logic [Width-1:0]  out_inv_q, out_div_q;
	status_t           out_stat_q, stat;

	assign shl      = ~r1[Width-1] & ge_sh;
	assign out_free = ~out_valid_q | rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid   = out_valid_q;
	assign rsp.inverse = out_inv_q;
	assign rsp.divisor = out_div_q;
	assign rsp.status  = out_stat_q;

	always_comb begin
		if (m_q[Width-1:1] == '0) begin
			stat = STAT_BAD_MOD;
		end else if (r0 != Width'(1)) begin
			stat = STAT_NO_INV;
		end else begin
			stat = STAT_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (r1 == '0) ? S_DONE : S_ALIGN;
			end
			S_ALIGN: begin
				if (!shl) state_d = (k_q == '0) ? S_CHECK : S_SUBT;
			end
			S_SUBT: begin
				if (k_q == '0) state_d = S_CHECK;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.ld_r0 = req.modulus;
		ctrl.ld_r1 = req.value;
		case (state_q)
			S_IDLE: begin
				if (req.valid) ctrl.op = OP_LOAD;
			end
			S_ALIGN: begin
				if (shl) ctrl.op = OP_SHL;
				else ctrl.op = (k_q == '0) ? OP_SUB_SWAP : OP_SUB_SHR;
			end
			S_SUBT: begin
				ctrl.op = (k_q == '0) ? OP_SUB_SWAP : OP_SUB_SHR;
			end
			default: ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				m_q   <= req.modulus;
				odd_q <= 1'b1;
				k_q   <= '0;
			end
			OP_SHL: k_q <= k_q + 1'b1;
			OP_SUB_SHR: k_q <= k_q - 1'b1;
			OP_SUB_SWAP: odd_q <= ~odd_q;
			default: begin
			end
		endcase
		// remainder reached one: its coefficient is the inverse up to sign
		if (state_q == S_CHECK && r1 == Width'(1)) begin
			if (odd_q) inv_q <= s1;
			else inv_q <= (s1 == '0) ? '0 : m_q - s1;
		end
		if (state_q == S_DONE && out_free) begin
			out_div_q  <= r0;
			out_stat_q <= stat;
			out_inv_q  <= (stat == STAT_OK) ? inv_q : '0;
		end
	end
endmodule

// ----- tb/tb_modular_inverse_with_gcd_check_core.sv -----
`timescale 1ns / 100ps

module tb_modular_inverse_with_gcd_check_core;
	import mi_pkg::*;

	typedef logic [Width-1:0] word_t;

	typedef struct {
		word_t   inverse;
		word_t   divisor;
		status_t status;
	} answer_t;

	class inverse_scoreboard;
		answer_t pending[$];
		int      errors;
		int      checked;
		int      counts[3];

		function automatic word_t euclid_gcd(word_t a, word_t b);
			word_t r;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			return a;
		endfunction

		// extended euclid on magnitudes, sign tracked by step parity
		function automatic word_t solve_inverse(word_t a, word_t m);
			logic [63:0] r0, r1, r2, s0, s1, s2, q;
			bit          odd;
			r0 = m;
			r1 = a;
			s0 = 0;
			s1 = 1;
			odd = 1;
			while (r1 > 1) begin
				q = r0 / r1;
				r2 = r0 - q * r1;
				s2 = s0 + q * s1;
				r0 = r1;
				r1 = r2;
				s0 = s1;
				s1 = s2;
				odd = !odd;
			end
			if (r1 != 1)
				return '0;
			s1 = s1 % m;
			if (odd)
				return s1[Width-1:0];
			return word_t'((m - s1) % m);
		endfunction

		function void note_request(word_t v, word_t m);
			answer_t a;
			a.divisor = euclid_gcd(v, m);
			a.inverse = '0;
			if (m < 2)
				a.status = STAT_BAD_MOD;
			else if (a.divisor != 1)
				a.status = STAT_NO_INV;
			else begin
				a.status = STAT_OK;
				a.inverse = solve_inverse(v % m, m);
			end
			pending.push_back(a);
		endfunction

		function void check_response(word_t inv, word_t div, logic [1:0] st);
			answer_t a;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response inv=%0d div=%0d st=%0d", $time, inv, div, st);
				errors++;
				return;
			end
			a = pending.pop_front();
			checked++;
			if (st <= 2)
				counts[st]++;
			if (inv !== a.inverse) begin
				$display("%0t: inverse expected %0d actual %0d", $time, a.inverse, inv);
				errors++;
			end
			if (div !== a.divisor) begin
				$display("%0t: divisor expected %0d actual %0d", $time, a.divisor, div);
				errors++;
			end
			if (st !== a.status) begin
				$display("%0t: status expected %0d actual %0d", $time, a.status, st);
				errors++;
			end
		endfunction
	endclass

	localparam int IdleLimit = 20000;

	logic clk;
	logic arst_n;
	bit   quiet_phase;
	int   stall_cycles;

	mi_req_if req ();
	mi_rsp_if rsp ();

	inverse_scoreboard board;

	modular_inverse_with_gcd_check_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic bit take_break();
		return !quiet_phase && ($urandom_range(99) < 18);
	endfunction

	// valid stays high after an accept; only a break in the next call or the end of the run drops it
	task automatic send_request(word_t v, word_t m);
		while (take_break()) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.value <= v;
		req.modulus <= m;
		do
			@(posedge clk);
		while (!req.ready);
		board.note_request(v, m);
		@(negedge clk);
	endtask

	function automatic word_t random_operand();
		word_t w;
		case ($urandom_range(5))
			0: w = word_t'($urandom_range(20));
			1: w = word_t'($urandom_range(1000));
			2: w = word_t'($urandom) >> $urandom_range(Width - 1);
			3: w = word_t'({Width{1'b1}} - $urandom_range(5));
			default: w = word_t'($urandom);
		endcase
		return w;
	endfunction

	// response side, with random backpressure
	always @(negedge clk)
		rsp.ready <= !take_break();

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response(rsp.inverse, rsp.divisor, rsp.status);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= IdleLimit) begin
			$display("%0t: no progress, %0d responses outstanding", $time, board.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		word_t v, m;
		word_t full;
		board = new();
		full = {Width{1'b1}};
		req.valid = 0;
		req.value = '0;
		req.modulus = '0;
		rsp.ready = 0;
		quiet_phase = 0;
		stall_cycles = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed corners: invalid moduli, zero value, reduction, full-width operands
		send_request(0, 0);
		send_request(5, 0);
		send_request(full, 0);
		send_request(0, 1);
		send_request(full, 1);
		send_request(0, 2);
		send_request(0, 7);
		send_request(1, 2);
		send_request(3, 7);
		send_request(10, 7);
		send_request(7, 7);
		send_request(6, 9);
		send_request(full, full);
		send_request(word_t'(full - 1'b1), full);
		send_request(1, full);
		send_request(full, 2);
		send_request(2, full);
		send_request(full, word_t'(full - 1'b1));
		send_request(word_t'(32'h55555555), word_t'(32'h2AAAAAAA));
		send_request(word_t'(1836311903), word_t'(1134903170));
		send_request(1, word_t'(2147483629));
		send_request(full, word_t'(1 << (Width - 1)));

		for (int i = 0; i < 1630; i++) begin
			quiet_phase = (i >= 700 && i < 900);
			v = random_operand();
			m = random_operand();
			if ($urandom_range(9) == 0)
				m = word_t'($urandom_range(1));
			send_request(v, m);
		end
		req.valid <= 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("checked %0d responses: %0d inverses, %0d without inverse, %0d bad modulus",
			board.checked, board.counts[0], board.counts[1], board.counts[2]);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
